// ----- design/assert_macros.svh -----
// Assertion shorthands used by the checker file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ISE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("insertion sort check failed");

// Next-cycle implication.
`define ISE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("insertion sort check failed");

`endif

// ----- design/ise_pkg.sv -----
package ise_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_load;
    logic rd_en;
    logic wr_en;
    logic wr_sel_key;
    logic out_load;
    logic out_end;
    logic out_ovf;
  } cmd_t;

endpackage

// ----- design/ise_datapath.sv -----
module ise_datapath
  import ise_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic signed [VALUE_W-1:0]           in_value,
  input  cmd_t                                cmd,
  input  logic [$clog2(MAX_ITEMS)-1:0]        rd_addr,
  input  logic [$clog2(MAX_ITEMS)-1:0]        wr_addr,
  output logic                                gt,
  output logic signed [VALUE_W-1:0]           out_sorted_value,
  output logic                                out_end_of_set,
  output logic                                out_overflow
);

  logic signed [VALUE_W-1:0] mem [MAX_ITEMS];
  logic signed [VALUE_W-1:0] key_r;
  logic signed [VALUE_W-1:0] rd_data_r;
  logic signed [VALUE_W-1:0] val_r;
  logic                      end_r;
  logic                      ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_sel_key ? key_r : rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      key_r <= in_value;
    end
    if (cmd.out_load) begin
      val_r <= rd_data_r;
      end_r <= cmd.out_end;
      ovf_r <= cmd.out_ovf;
    end
  end

  // Strictly greater keeps equal values in arrival order.
  assign gt = rd_data_r > key_r;

  assign out_sorted_value = val_r;
  assign out_end_of_set   = end_r;
  assign out_overflow     = ovf_r;

endmodule

// ----- design/ise_ctrl.sv -----
module ise_ctrl
  import ise_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_is_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           gt,
  output cmd_t                           cmd,
  output logic [$clog2(MAX_ITEMS)-1:0]   rd_addr,
  output logic [$clog2(MAX_ITEMS)-1:0]   wr_addr
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             dropped_r, dropped_nxt;
  logic             last_r, last_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] rd_addr_full;

  logic in_acc;
  logic full;
  logic shift;
  logic out_load;
  logic issue;
  logic emit_done;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign full     = (count_r == MAX_C);
  assign shift    = (state_r == S_INSERT) && (pos_r != '0) && gt;

  // The read data register acts as a second output stage, so the set
  // streams out at one result per cycle while the consumer keeps up.
  assign out_load  = (state_r == S_EMIT) && pend_r && (!out_valid_r || out_ready);
  assign issue     = (state_r == S_EMIT) && (!pend_r || out_load) && (idx_r != count_r);
  assign emit_done = (state_r == S_EMIT) && (idx_r == count_r) && (!pend_r || out_load);

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!full) begin
            state_nxt = S_INSERT;
          end else if (in_is_last) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_INSERT: begin
        if (!shift) begin
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    dropped_nxt   = dropped_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r;

    if (in_acc) begin
      pos_nxt  = count_r;
      last_nxt = in_is_last;
      if (full) begin
        dropped_nxt = 1'b1;
      end
    end
    if (shift) begin
      pos_nxt = pos_r - ONE_C;
    end
    if ((state_r == S_INSERT) && !shift) begin
      count_nxt = count_r + ONE_C;
    end

    if (issue) begin
      idx_nxt       = idx_r + ONE_C;
      pend_nxt      = 1'b1;
      pend_last_nxt = ((idx_r + ONE_C) == count_r);
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (emit_done) begin
      count_nxt   = '0;
      idx_nxt     = '0;
      dropped_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd            = '0;
    rd_addr_full   = idx_r;
    cmd.out_load   = out_load;
    cmd.out_end    = pend_last_r;
    cmd.out_ovf    = dropped_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.key_load = in_acc;
        cmd.rd_en    = in_acc && !full;
        rd_addr_full = count_r - ONE_C;
      end
      S_INSERT: begin
        cmd.rd_en      = shift;
        cmd.wr_en      = 1'b1;
        cmd.wr_sel_key = !shift;
        rd_addr_full   = pos_r - TWO_C;
      end
      S_EMIT: begin
        cmd.rd_en    = issue;
        rd_addr_full = idx_r;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign rd_addr = rd_addr_full[ADDR_W-1:0];
  assign wr_addr = pos_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      dropped_r   <= 1'b0;
      last_r      <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      dropped_r   <= dropped_nxt;
      last_r      <= last_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/insertion_sort_engine.sv -----
// Insertion of one value shifts each stored entry larger than it (0 to MAX_ITEMS - 1 of
// them) up one place; the shift loop over the store does one read and one write per cycle.
// After the last value is stored, the sorted results stream out at one per cycle while
// the consumer keeps up.
// Synchronous active-low reset empties the set and the output stage; store contents
// are left as they are.
module insertion_sort_engine
  import ise_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_is_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_sorted_value,
  output logic                      out_end_of_set,
  output logic                      out_overflow
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);

  cmd_t              cmd;
  logic              gt;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  ise_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_is_last (in_is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .gt         (gt),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  ise_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk              (clk),
    .in_value         (in_value),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .wr_addr          (wr_addr),
    .gt               (gt),
    .out_sorted_value (out_sorted_value),
    .out_end_of_set   (out_end_of_set),
    .out_overflow     (out_overflow)
  );

endmodule

// ----- design/ise_checker.sv -----
`include "assert_macros.svh"

module ise_checker
  import ise_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_is_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] out_sorted_value,
  input logic                      out_end_of_set,
  input logic                      out_overflow
);

  logic                      out_acc;
  logic                      have_prev_r;
  logic signed [VALUE_W-1:0] prev_val_r;
  logic                      prev_ovf_r;

  assign out_acc = out_valid && out_ready;

  // Remember the previous result of the current set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (out_acc) begin
      have_prev_r <= !out_end_of_set;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_val_r <= out_sorted_value;
      prev_ovf_r <= out_overflow;
    end
  end

  `ISE_ASSERT_IMPL(a_ascending, out_acc && have_prev_r, out_sorted_value >= prev_val_r)
  `ISE_ASSERT_IMPL(a_ovf_steady, out_acc && have_prev_r, out_overflow == prev_ovf_r)
  `ISE_ASSERT_NEXT(a_last_stalls_in, in_valid && in_ready && in_is_last, !in_ready)
  `ISE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sorted_value))

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (.*);
